// File: rtl/core/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the priority voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

	localparam int DEF_MAX_VOICES = 512;
	localparam int LIMIT_MIN      = 8;
	localparam int LIMIT_MAX      = 512;
	localparam int LIMIT_RESET    = 96;
	localparam int STEAL_CAP      = 63;
	localparam int CNT_W          = 6;

	typedef enum logic [2:0] {
		KIND_STOLEN   = 3'd0,
		KIND_GRANTED  = 3'd1,
		KIND_REJECTED = 3'd2,
		KIND_LOADFAIL = 3'd3,
		KIND_IGNORED  = 3'd4,
		KIND_RELEASED = 3'd5
	} kind_t;

	typedef enum logic {
		REG_ENABLED = 1'b0,
		REG_LIMIT   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic        busy;
		logic        stealable;
		logic [7:0]  prio;
		logic [63:0] serial;
	} entry_t;

	typedef struct packed {
		logic  load_req;
		logic  scan_start;
		logic  scan_step;
		logic  clr_step;
		logic  rd_release;
		logic  rel_fin;
		logic  steal;
		logic  grant;
		logic  serial_inc;
		logic  rej_inc;
		logic  emit;
		kind_t kind;
		logic  last;
	} cmd_t;

	typedef struct packed {
		logic req_release;
		logic enabled;
		logic path_present;
		logic load_ok;
		logic start_ok;
		logic occ_ge_limit;
		logic addr_last;
		logic found;
	} sts_t;

endpackage

// File: rtl/core/priority_voice_allocator.sv
// ----------------------------------------------------------------------------
// priority_voice_allocator
// Voice slot allocator with priority stealing, top level.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. Every result word is
// shown for one cycle with strobe high and cannot be held off, so the
// receiver must take each one as it comes. All slot state sits in one
// memory read one slot per cycle: a play request makes a full pass over
// all MAX_VOICES slots for each steal and for the free-slot search; a
// release or a request refused before any scan gives its result word
// without a pass. After reset a clearing pass over all MAX_VOICES slots
// keeps busy high; configuration writes are taken at any time.
module priority_voice_allocator #(
	parameter int MAX_VOICES = pva_pkg::DEF_MAX_VOICES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  priority_req,
	input  logic        stealable,
	input  logic        path_present,
	input  logic        load_ok,
	input  logic        start_ok,
	input  logic [8:0]  release_slot,
	output logic        strobe,
	output logic [2:0]  kind,
	output logic [8:0]  slot,
	output logic        last,
	output logic [9:0]  active_count,
	output logic [63:0] started_total,
	output logic [63:0] stolen_total,
	output logic [63:0] rejected_total
);
	import pva_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pva_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pva_dp #(.MAX_VOICES(MAX_VOICES)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.priority_req   (priority_req),
		.stealable      (stealable),
		.path_present   (path_present),
		.load_ok        (load_ok),
		.start_ok       (start_ok),
		.release_slot   (release_slot),
		.strobe         (strobe),
		.kind           (kind),
		.slot           (slot),
		.last           (last),
		.active_count   (active_count),
		.started_total  (started_total),
		.stolen_total   (stolen_total),
		.rejected_total (rejected_total)
	);

endmodule

// File: rtl/core/pva_ram.sv
// ----------------------------------------------------------------------------
// pva_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/pva_dp.sv
// ----------------------------------------------------------------------------
// pva_dp
// Datapath: slot memory, scan comparator, counters and result register.
// ----------------------------------------------------------------------------
module pva_dp #(
	parameter int MAX_VOICES = pva_pkg::DEF_MAX_VOICES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pva_pkg::cmd_t       cmd,
	output pva_pkg::sts_t       sts,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [9:0]          cfg_data,
	input  logic                req_type,
	input  logic [7:0]          priority_req,
	input  logic                stealable,
	input  logic                path_present,
	input  logic                load_ok,
	input  logic                start_ok,
	input  logic [8:0]          release_slot,
	output logic                strobe,
	output logic [2:0]          kind,
	output logic [8:0]          slot,
	output logic                last,
	output logic [9:0]          active_count,
	output logic [63:0]         started_total,
	output logic [63:0]         stolen_total,
	output logic [63:0]         rejected_total
);
	import pva_pkg::*;

	localparam int SW = $clog2(MAX_VOICES);
	localparam int DW = $bits(entry_t);
	localparam int RESET_LIMIT = (LIMIT_RESET > MAX_VOICES) ? MAX_VOICES : LIMIT_RESET;

	logic          req_type_q, steal_q, path_q, load_q, start_ok_q;
	logic [7:0]    prio_q;
	logic [8:0]    rel_slot_q;
	logic          enabled_q;
	logic [9:0]    limit_q, limit_d;
	logic [9:0]    occ_q, occ_d;
	logic [63:0]   serial_q, started_q, stolen_q, rejected_q;
	logic [63:0]   started_d, stolen_d, rejected_d;
	logic [SW-1:0] addr_q, idx_s1;
	logic          rd_v_s1;
	logic          found_q, free_found_q;
	logic [SW-1:0] best_slot_q, free_slot_q;
	logic [7:0]    best_prio_q;
	logic [63:0]   best_serial_q;

	logic          we, re;
	logic [SW-1:0] waddr, raddr, rel_addr;
	entry_t        wdata, rdata;
	logic [DW-1:0] rdata_raw;
	logic          rel_in_range, rel_hit, cand, better;
	int            cfg_v;

	pva_ram #(.WIDTH(DW), .DEPTH(MAX_VOICES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_raw)
	);
	assign rdata = entry_t'(rdata_raw);

	assign rel_addr     = SW'(rel_slot_q);
	assign rel_in_range = 32'(rel_slot_q) < 32'(MAX_VOICES);
	assign rel_hit      = cmd.rel_fin && rel_in_range && rdata.busy;

	assign cand   = rdata.busy && rdata.stealable && (rdata.prio <= prio_q);
	assign better = !found_q || (rdata.prio < best_prio_q) ||
		((rdata.prio == best_prio_q) && (rdata.serial < best_serial_q));

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.steal) begin
			we    = 1'b1;
			waddr = best_slot_q;
		end else if (rel_hit) begin
			we    = 1'b1;
			waddr = rel_addr;
		end else if (cmd.grant && free_found_q) begin
			we    = 1'b1;
			waddr = free_slot_q;
			wdata = '{busy: 1'b1, stealable: steal_q, prio: prio_q, serial: serial_q};
		end
		re    = cmd.scan_step || cmd.rd_release;
		raddr = cmd.rd_release ? rel_addr : addr_q;
	end

	always_comb begin
		occ_d = occ_q;
		if (cmd.steal || rel_hit) begin
			occ_d = occ_q - 10'd1;
		end else if (cmd.grant && free_found_q) begin
			occ_d = occ_q + 10'd1;
		end
		started_d  = (cmd.grant && free_found_q) ? started_q + 64'd1 : started_q;
		stolen_d   = cmd.steal ? stolen_q + 64'd1 : stolen_q;
		rejected_d = cmd.rej_inc ? rejected_q + 64'd1 : rejected_q;
		cfg_v      = int'(cfg_data);
		if (cfg_v < LIMIT_MIN) begin
			cfg_v = LIMIT_MIN;
		end
		if (cfg_v > LIMIT_MAX) begin
			cfg_v = LIMIT_MAX;
		end
		if (cfg_v > MAX_VOICES) begin
			cfg_v = MAX_VOICES;
		end
		limit_d = 10'(cfg_v);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q <= req_type;
			prio_q     <= priority_req;
			steal_q    <= stealable;
			path_q     <= path_present;
			load_q     <= load_ok;
			start_ok_q <= start_ok;
			rel_slot_q <= release_slot;
		end
		idx_s1 <= addr_q;
		if (rd_v_s1 && cand && better) begin
			best_slot_q   <= idx_s1;
			best_prio_q   <= rdata.prio;
			best_serial_q <= rdata.serial;
		end
		if (rd_v_s1 && !rdata.busy && !free_found_q) begin
			free_slot_q <= idx_s1;
		end
		if (cmd.emit) begin
			kind           <= cmd.kind;
			last           <= cmd.last;
			active_count   <= occ_d;
			started_total  <= started_d;
			stolen_total   <= stolen_d;
			rejected_total <= rejected_d;
			unique case (cmd.kind)
				KIND_STOLEN:   slot <= 9'(best_slot_q);
				KIND_GRANTED:  slot <= 9'(free_slot_q);
				KIND_RELEASED: slot <= rel_slot_q;
				default:       slot <= 9'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			limit_q      <= 10'(RESET_LIMIT);
			occ_q        <= '0;
			serial_q     <= '0;
			started_q    <= '0;
			stolen_q     <= '0;
			rejected_q   <= '0;
			addr_q       <= '0;
			rd_v_s1      <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			strobe       <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ENABLED) begin
					enabled_q <= cfg_data[0];
				end else begin
					limit_q <= limit_d;
				end
			end
			occ_q      <= occ_d;
			started_q  <= started_d;
			stolen_q   <= stolen_d;
			rejected_q <= rejected_d;
			if (cmd.serial_inc) begin
				serial_q <= serial_q + 64'd1;
			end
			if (cmd.scan_start) begin
				addr_q       <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.scan_step || cmd.clr_step) begin
				addr_q <= addr_q + SW'(1);
			end
			rd_v_s1 <= cmd.scan_step;
			if (rd_v_s1 && cand) begin
				found_q <= 1'b1;
			end
			if (rd_v_s1 && !rdata.busy) begin
				free_found_q <= 1'b1;
			end
			strobe <= cmd.emit;
		end
	end

	assign sts = '{
		req_release:  req_type_q,
		enabled:      enabled_q,
		path_present: path_q,
		load_ok:      load_q,
		start_ok:     start_ok_q,
		occ_ge_limit: occ_q >= limit_q,
		addr_last:    addr_q == SW'(MAX_VOICES - 1),
		found:        found_q
	};

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= LIMIT_MAX)
		else $error("occupancy beyond the slot limit");
	a_steal_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.steal |-> found_q)
		else $error("steal without a candidate");
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grant |-> free_found_q)
		else $error("grant without a free slot");
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> strobe && (active_count == occ_q))
		else $error("word not presented after emit");

endmodule

// File: rtl/core/pva_ctrl.sv
// ----------------------------------------------------------------------------
// pva_ctrl
// Controller: sequences clearing, scans, steals, grants and releases.
// ----------------------------------------------------------------------------
module pva_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pva_pkg::sts_t sts,
	output pva_pkg::cmd_t cmd
);
	import pva_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_SDRAIN, S_SDEC,
		S_LOAD, S_FSCAN, S_FDRAIN, S_FDEC, S_REL
	} state_t;

	state_t          state_q, state_d;
	logic [CNT_W-1:0] n_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.kind = KIND_IGNORED;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.addr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (sts.req_release) begin
					cmd.rd_release = 1'b1;
					state_d        = S_REL;
				end else if (!sts.enabled || !sts.path_present) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_IGNORED;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end else if (sts.occ_ge_limit) begin
					if (n_q == CNT_W'(STEAL_CAP)) begin
						cmd.rej_inc = 1'b1;
						cmd.emit    = 1'b1;
						cmd.kind    = KIND_REJECTED;
						cmd.last    = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end else begin
					state_d = S_LOAD;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.addr_last) begin
					state_d = S_SDRAIN;
				end
			end
			S_SDRAIN: state_d = S_SDEC;
			S_SDEC: begin
				cmd.emit = 1'b1;
				if (sts.found) begin
					cmd.steal = 1'b1;
					cmd.kind  = KIND_STOLEN;
					state_d   = S_CHECK;
				end else begin
					cmd.rej_inc = 1'b1;
					cmd.kind    = KIND_REJECTED;
					cmd.last    = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_LOAD: begin
				if (!sts.load_ok) begin
					cmd.rej_inc = 1'b1;
					cmd.emit    = 1'b1;
					cmd.kind    = KIND_LOADFAIL;
					cmd.last    = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.serial_inc = 1'b1;
					if (!sts.start_ok) begin
						cmd.emit = 1'b1;
						cmd.kind = KIND_IGNORED;
						cmd.last = 1'b1;
						state_d  = S_IDLE;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_FSCAN;
					end
				end
			end
			S_FSCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.addr_last) begin
					state_d = S_FDRAIN;
				end
			end
			S_FDRAIN: state_d = S_FDEC;
			S_FDEC: begin
				cmd.grant = 1'b1;
				cmd.emit  = 1'b1;
				cmd.kind  = KIND_GRANTED;
				cmd.last  = 1'b1;
				state_d   = S_IDLE;
			end
			S_REL: begin
				cmd.rel_fin = 1'b1;
				cmd.emit    = 1'b1;
				cmd.kind    = KIND_RELEASED;
				cmd.last    = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load_req) begin
				n_q <= '0;
			end else if (cmd.steal) begin
				n_q <= n_q + CNT_W'(1);
			end
		end
	end

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.steal |-> (n_q < CNT_W'(STEAL_CAP)))
		else $error("steal beyond the per-request cap");

endmodule

// File: test/tb_priority_voice_allocator.sv
// ----------------------------------------------------------------------------
// tb_priority_voice_allocator
// Self-checking bench for the priority voice allocator. Request words are
// driven through the start/busy handshake while a slot-level predictor works
// out the result words that each accepted request must give: steals,
// grants, rejects, load and start failures, releases, and the running
// totals. A monitor compares every strobed result word with the oldest
// prediction. Directed tests cover the disabled engine, limit clamping,
// every result kind and the steal cap; a random phase follows with bursty
// idling and changing limits.
// ----------------------------------------------------------------------------
module tb_priority_voice_allocator;
	import pva_pkg::*;

	localparam int NSLOTS   = DEF_MAX_VOICES;
	localparam int WD_LIMIT = 6000;

	typedef struct {
		kind_t       kind;
		logic [8:0]  slot;
		logic        last;
		logic [9:0]  active;
		logic [63:0] started;
		logic [63:0] stolen;
		logic [63:0] rejected;
	} voice_result_t;

	typedef struct {
		logic       rel;
		logic [7:0] prio;
		logic       steal_ok;
		logic       path;
		logic       load;
		logic       run;
		logic [8:0] rslot;
	} voice_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [9:0]  cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic        req_type = 1'b0;
	logic [7:0]  priority_req = '0;
	logic        stealable = 1'b0;
	logic        path_present = 1'b0;
	logic        load_ok = 1'b0;
	logic        start_ok = 1'b0;
	logic [8:0]  release_slot = '0;
	logic        strobe;
	logic [2:0]  kind;
	logic [8:0]  slot;
	logic        last;
	logic [9:0]  active_count;
	logic [63:0] started_total;
	logic [63:0] stolen_total;
	logic [63:0] rejected_total;

	priority_voice_allocator dut (.*);

	// predictor state
	logic        m_enabled;
	int unsigned m_limit;
	logic        m_busy [NSLOTS];
	logic [7:0]  m_prio [NSLOTS];
	logic        m_steal [NSLOTS];
	logic [63:0] m_serial [NSLOTS];
	logic [63:0] m_serial_cnt, m_started, m_stolen, m_rejected;
	int unsigned m_occ;

	voice_result_t pending_results [$];
	int  mismatches = 0;
	int  quiet_cycles = 0;
	bit  calm = 0;

	initial forever #6 clk = ~clk;

	function automatic void model_reset();
		m_enabled = 1'b0;
		m_limit = LIMIT_RESET;
		foreach (m_busy[i]) begin
			m_busy[i] = 1'b0;
			m_prio[i] = '0;
			m_steal[i] = 1'b0;
			m_serial[i] = '0;
		end
		m_serial_cnt = '0;
		m_started = '0;
		m_stolen = '0;
		m_rejected = '0;
		m_occ = 0;
	endfunction

	function automatic void push_result(kind_t k, logic [8:0] s, logic l);
		voice_result_t r;
		r.kind = k;
		r.slot = s;
		r.last = l;
		r.active = m_occ[9:0];
		r.started = m_started;
		r.stolen = m_stolen;
		r.rejected = m_rejected;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic int pick_victim(logic [7:0] p);
		int best;
		best = -1;
		for (int i = 0; i < NSLOTS; i++) begin
			if (!m_busy[i] || !m_steal[i] || m_prio[i] > p)
				continue;
			if (best < 0 || m_prio[i] < m_prio[best] ||
			    (m_prio[i] == m_prio[best] && m_serial[i] < m_serial[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic void predict_request(voice_req_t q);
		int n;
		int v;
		int f;
		n = 0;
		if (q.rel) begin
			if (m_busy[q.rslot]) begin
				m_busy[q.rslot] = 1'b0;
				m_occ--;
			end
			push_result(KIND_RELEASED, q.rslot, 1'b1);
			return;
		end
		if (!m_enabled || !q.path) begin
			push_result(KIND_IGNORED, '0, 1'b1);
			return;
		end
		while (m_occ >= m_limit) begin
			v = (n < STEAL_CAP) ? pick_victim(q.prio) : -1;
			if (v < 0) begin
				m_rejected++;
				push_result(KIND_REJECTED, '0, 1'b1);
				return;
			end
			m_busy[v] = 1'b0;
			m_occ--;
			m_stolen++;
			push_result(KIND_STOLEN, v[8:0], 1'b0);
			n++;
		end
		if (!q.load) begin
			m_rejected++;
			push_result(KIND_LOADFAIL, '0, 1'b1);
			return;
		end
		m_serial_cnt++;
		if (!q.run) begin
			push_result(KIND_IGNORED, '0, 1'b1);
			return;
		end
		f = 0;
		while (m_busy[f])
			f++;
		m_busy[f] = 1'b1;
		m_prio[f] = q.prio;
		m_steal[f] = q.steal_ok;
		m_serial[f] = m_serial_cnt;
		m_occ++;
		m_started++;
		push_result(KIND_GRANTED, f[8:0], 1'b1);
	endfunction

	// result check and watchdog
	always @(posedge clk) begin
		voice_result_t e;
		if (arst_n) begin
			if ((start && !busy) || strobe)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
			if (strobe) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: kind %0d slot %0d", kind, slot);
				end else begin
					e = pending_results.pop_front();
					if (kind !== e.kind || slot !== e.slot || last !== e.last ||
					    active_count !== e.active || started_total !== e.started ||
					    stolen_total !== e.stolen || rejected_total !== e.rejected) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch exp k%0d s%0d l%0d a%0d %0d/%0d/%0d",
							         e.kind, e.slot, e.last, e.active, e.started,
							         e.stolen, e.rejected);
							$display("         got k%0d s%0d l%0d a%0d %0d/%0d/%0d",
							         kind, slot, last, active_count, started_total,
							         stolen_total, rejected_total);
						end
					end
				end
			end
		end
	end

	task automatic send_word(voice_req_t q);
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_type <= q.rel;
		priority_req <= q.prio;
		stealable <= q.steal_ok;
		path_present <= q.path;
		load_ok <= q.load;
		start_ok <= q.run;
		release_slot <= q.rslot;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_request(q);
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [9:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENABLED) begin
			m_enabled = val[0];
		end else begin
			m_limit = (val < LIMIT_MIN) ? LIMIT_MIN : (val > LIMIT_MAX) ? LIMIT_MAX : val;
		end
	endtask

	function automatic voice_req_t play(logic [7:0] p, logic s, logic pa, logic l, logic r);
		voice_req_t q;
		q = '{1'b0, p, s, pa, l, r, 9'h0};
		return q;
	endfunction

	function automatic voice_req_t free_slot(logic [8:0] s);
		voice_req_t q;
		q = '{1'b1, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
		      1'($urandom), s};
		return q;
	endfunction

	function automatic int some_busy_slot();
		int c;
		int k;
		c = $urandom_range(0, m_occ - 1);
		k = 0;
		for (int i = 0; i < NSLOTS; i++) begin
			if (m_busy[i]) begin
				if (k == c)
					return i;
				k++;
			end
		end
		return 0;
	endfunction

	task automatic test_disabled();
		send_word(play(8'hff, 1'b1, 1'b1, 1'b1, 1'b1));
		send_word(free_slot(9'h1ff));
		write_reg(REG_LIMIT, 10'd0);
		write_reg(REG_LIMIT, 10'h3ff);
		send_word(free_slot(9'd0));
	endtask

	task automatic test_kinds();
		write_reg(REG_ENABLED, 10'd1);
		write_reg(REG_LIMIT, 10'd8);
		send_word(play(8'd0, 1'b1, 1'b0, 1'b1, 1'b1));
		send_word(play(8'd10, 1'b1, 1'b1, 1'b0, 1'b1));
		send_word(play(8'd10, 1'b1, 1'b1, 1'b1, 1'b0));
		for (int i = 0; i < 8; i++)
			send_word(play(i == 7 ? 8'hff : 8'(i * 20), i != 3, 1'b1, 1'b1, 1'b1));
		send_word(play(8'd50, 1'b1, 1'b1, 1'b1, 1'b1));
		send_word(play(8'd0, 1'b0, 1'b1, 1'b0, 1'b1));
		send_word(play(8'hff, 1'b0, 1'b1, 1'b1, 1'b0));
		send_word(play(8'd0, 1'b1, 1'b1, 1'b1, 1'b1));
		send_word(free_slot(9'd2));
		send_word(free_slot(9'd2));
		send_word(free_slot(9'd300));
		send_word(play(8'd200, 1'b0, 1'b1, 1'b1, 1'b1));
	endtask

	task automatic test_steal_cap();
		voice_req_t q;
		write_reg(REG_LIMIT, 10'd512);
		calm = 1;
		while (m_occ < 72)
			send_word(play(8'(m_occ % 3), 1'b1, 1'b1, 1'b1, 1'b1));
		calm = 0;
		write_reg(REG_LIMIT, 10'd5);
		q = play(8'hff, 1'b1, 1'b1, 1'b1, 1'b1);
		send_word(q);
		write_reg(REG_LIMIT, 10'd8);
		send_word(q);
	endtask

	task automatic test_random();
		voice_req_t q;
		for (int n = 0; n < 30; n++) begin
			if (n % 10 == 9) begin
				write_reg(REG_LIMIT, 10'($urandom_range(8, 16)));
				write_reg(REG_ENABLED, 10'($urandom_range(0, 5) != 0));
			end
			if (n == 22) begin
				write_reg(REG_ENABLED, 10'h3ff);
				calm = 1;
			end
			if ($urandom_range(0, 3) == 0) begin
				if (m_occ > 0 && $urandom_range(0, 7) != 0)
					q = free_slot(9'(some_busy_slot()));
				else
					q = free_slot(9'($urandom));
			end else begin
				q = play(8'($urandom), $urandom_range(0, 3) != 0,
				         $urandom_range(0, 15) != 0,
				         $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
			end
			send_word(q);
		end
	endtask

	initial begin
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_disabled();
		test_kinds();
		test_steal_cap();
		test_random();
		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
